[rtl/iefq_pkg.sv]
// types, codes and constants for the input event queue top level
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package iefq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 64;
   localparam int FILL_W              = 7;
   localparam int DROP_W              = 32;
   localparam int ENTRY_W             = 128;

   localparam logic [15:0] SYNC_TYPE   = 16'd0;
   localparam logic [15:0] REPORT_CODE = 16'd0;
   localparam logic [15:0] MARKER_CODE = 16'd3;

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_POP  = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_QUEUED      = 3'd0,
      ST_OVERFLOW    = 3'd1,
      ST_FRAME_DROP  = 3'd2,
      ST_MARKER_Q    = 3'd3,
      ST_MARKER_LOST = 3'd4,
      ST_POPPED      = 3'd5,
      ST_EMPTY       = 3'd6,
      ST_GONE        = 3'd7
   } status_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [15:0]        event_type;
      logic [15:0]        event_code;
      logic signed [31:0] event_value;
      logic [63:0]        event_stamp;
      logic               batch_last;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [15:0]        out_type;
      logic [15:0]        out_code;
      logic signed [31:0] out_value;
      logic [63:0]        out_stamp;
      logic               wake;
      logic [DROP_W-1:0]  dropped_count;
      logic [FILL_W-1:0]  fill_level;
   } rsp_type;

   // queue entry layout: type, code, value, stamp
   typedef struct packed {
      logic [15:0] ev_type;
      logic [15:0] ev_code;
      logic [31:0] ev_value;
      logic [63:0] ev_stamp;
   } entry_type;

endpackage

`default_nettype wire

[rtl/input_event_queue_frame_drop.sv]
// top level of the bounded input event queue with frame aware overflow drop
// depends on iefq_pkg and iefq_ram
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   A command (push or pop) is a transfer on req_payload at a rising edge where
//   start is high and busy is low. busy stays low: one command per cycle.
//   Every command gives exactly one response on rsp_data, marked by
//   rsp_strobe for one cycle, in the cycle right after the command.
//   The receiver cannot stall; responses are never held.
//   Events live in one ram of QUEUE_DEPTH entries (event and stamp side by
//   side). A push writes the entry in its command cycle; a pop reads it in its
//   command cycle and the registered read data forms the response. A push
//   right after a pop or a pop right after a push touch the ram in
//   different cycles, so no forwarding is needed.
//   csr_we/csr_wdata write the device-gone bit, to be changed while idle.
//   Reset (synchronous, active high) empties the queue, clears the drop
//   counter, frame-drop mode, batch state and the device-gone bit; the ram
//   is not cleared, only written entries are ever read.
module input_event_queue_frame_drop #(
   parameter int QUEUE_DEPTH = iefq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire iefq_pkg::req_type req_payload,
   output logic                   rsp_strobe,
   output iefq_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic              csr_wdata
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   logic [PTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       frame_ff, frame_in;
   logic [iefq_pkg::DROP_W-1:0] drop_ff, drop_in;
   logic                       bqa_ff, bqa_in;
   logic                       gone_ff;

   logic                       rsp_strobe_ff;
   logic                       pop_ff;
   iefq_pkg::status_type       status_ff, status_in;
   logic                       wake_ff, wake_in;

   logic                       accept;
   logic                       full;
   logic                       ram_we, ram_re;
   iefq_pkg::entry_type        wentry;
   iefq_pkg::entry_type        rentry;
   logic [iefq_pkg::ENTRY_W-1:0] ram_rdata;
   logic                       queued;

   assign busy   = 1'b0;
   assign accept = start & ~busy;
   assign full   = (count_ff == CNT_FULL);

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      frame_in  = frame_ff;
      drop_in   = drop_ff;
      bqa_in    = bqa_ff;
      status_in = iefq_pkg::ST_GONE;
      wake_in   = 1'b0;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      queued    = 1'b0;
      wentry.ev_type  = req_payload.event_type;
      wentry.ev_code  = req_payload.event_code;
      wentry.ev_value = req_payload.event_value;
      wentry.ev_stamp = req_payload.event_stamp;

      priority if (gone_ff) begin
         status_in = iefq_pkg::ST_GONE;
      end else if (req_payload.cmd == iefq_pkg::CMD_POP) begin
         if (count_ff == '0) begin
            status_in = iefq_pkg::ST_EMPTY;
         end else begin
            ram_re    = 1'b1;
            rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
            count_in  = count_ff - CNT_W'(1);
            status_in = iefq_pkg::ST_POPPED;
         end
      end else begin
         if (frame_ff) begin
            if (req_payload.event_type == iefq_pkg::SYNC_TYPE &&
                req_payload.event_code == iefq_pkg::REPORT_CODE) begin
               // report replaced by a dropped marker
               wentry.ev_type  = iefq_pkg::SYNC_TYPE;
               wentry.ev_code  = iefq_pkg::MARKER_CODE;
               wentry.ev_value = '0;
               wentry.ev_stamp = '0;
               frame_in        = 1'b0;
               if (!full) begin
                  queued    = 1'b1;
                  status_in = iefq_pkg::ST_MARKER_Q;
               end else begin
                  status_in = iefq_pkg::ST_MARKER_LOST;
               end
            end else begin
               status_in = iefq_pkg::ST_FRAME_DROP;
            end
         end else if (!full) begin
            queued    = 1'b1;
            status_in = iefq_pkg::ST_QUEUED;
         end else begin
            if (drop_ff != '1) begin
               drop_in = drop_ff + iefq_pkg::DROP_W'(1);
            end
            frame_in  = 1'b1;
            status_in = iefq_pkg::ST_OVERFLOW;
         end
         if (queued) begin
            ram_we    = 1'b1;
            wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
            count_in  = count_ff + CNT_W'(1);
            bqa_in    = 1'b1;
         end
         if (req_payload.batch_last) begin
            wake_in = bqa_in;
            bqa_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff     <= '0;
         wr_ptr_ff     <= '0;
         count_ff      <= '0;
         frame_ff      <= 1'b0;
         drop_ff       <= '0;
         bqa_ff        <= 1'b0;
         gone_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         pop_ff        <= 1'b0;
      end else begin
         if (csr_we) begin
            gone_ff <= csr_wdata;
         end
         rsp_strobe_ff <= accept;
         pop_ff        <= accept & ram_re;
         if (accept) begin
            rd_ptr_ff <= rd_ptr_in;
            wr_ptr_ff <= wr_ptr_in;
            count_ff  <= count_in;
            frame_ff  <= frame_in;
            drop_ff   <= drop_in;
            bqa_ff    <= bqa_in;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         wake_ff   <= wake_in;
      end
   end

   iefq_ram #(
      .WIDTH (iefq_pkg::ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock (clock),
      .we    (accept & ram_we),
      .waddr (wr_ptr_ff),
      .wdata (wentry),
      .re    (accept & ram_re),
      .raddr (rd_ptr_ff),
      .rdata (ram_rdata)
   );

   assign rentry     = ram_rdata;
   assign rsp_strobe = rsp_strobe_ff;

   always_comb begin
      rsp_data.status        = status_ff;
      rsp_data.wake          = wake_ff;
      rsp_data.dropped_count = drop_ff;
      rsp_data.fill_level    = iefq_pkg::FILL_W'(count_ff);
      rsp_data.out_type      = pop_ff ? rentry.ev_type  : '0;
      rsp_data.out_code      = pop_ff ? rentry.ev_code  : '0;
      rsp_data.out_value     = pop_ff ? rentry.ev_value : '0;
      rsp_data.out_stamp     = pop_ff ? rentry.ev_stamp : '0;
   end

   // checks

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count above depth");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CNT_FULL) |-> (rd_ptr_ff == wr_ptr_ff))
      else $error("pointers disagree with empty or full count");

   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("command without response");

   a_drop_mono: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> drop_ff >= $past(drop_ff))
      else $error("drop counter went down");

endmodule

`default_nettype wire

[rtl/iefq_ram.sv]
// generic simple dual port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module iefq_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire
